@@ hdl/particle_kinetic_energy_sum_unit_assert.svh @@
// assertion macros used by the checker file
`ifndef PARTICLE_KINETIC_ENERGY_SUM_UNIT_ASSERT_SVH
`define PARTICLE_KINETIC_ENERGY_SUM_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define PKES_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is low
`define PKES_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/pkes_pkg.sv @@
// ----------------------------------------------------------------------------
// pkes_pkg
// Shared types and constants of the kinetic energy sum unit.
// ----------------------------------------------------------------------------
package pkes_pkg;

    localparam int NUM_COEF   = 12;
    localparam int CELL_REQ_W = 12;

    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_PARTICLE = 1'b1;

    localparam logic CFG_CHARGE_STEP = 1'b0;
    localparam logic CFG_MASS        = 1'b1;

    typedef struct packed {
        logic [NUM_COEF-1:0][31:0] coef;
        logic [2:0][15:0]          off;
        logic [2:0][31:0]          mom;
        logic [31:0]               weight;
        logic                      last;
    } t_particle;

endpackage

@@ hdl/particle_kinetic_energy_sum_unit.sv @@
// one particle holds the back end from its take through 6 steps per axis,
// 32 square root steps, 68 divide steps, 4 partial products and 1 accumulate
// a last particle adds an emit step, which waits while a result is still unread
// a load is taken while the front holds no particle or the queue has room
// synchronous active-low reset clears control, accumulator and config
// (charge factor 0, mass 1.0); the coefficient store is not cleared
module particle_kinetic_energy_sum_unit import pkes_pkg::*; #(
    parameter int CELLS = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_cmd,
    input  logic [CELL_REQ_W-1:0] i_cell_req,
    input  logic [3:0]            i_coeff_select,
    input  logic [31:0]           i_coeff_value,
    input  logic [15:0]           i_offset_x,
    input  logic [15:0]           i_offset_y,
    input  logic [15:0]           i_offset_z,
    input  logic [31:0]           i_mom_x,
    input  logic [31:0]           i_mom_y,
    input  logic [31:0]           i_mom_z,
    input  logic [31:0]           i_weight,
    input  logic                  i_last,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [63:0]           o_energy_sum,
    output logic                  o_saturated,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [31:0]           i_cfg_data
);

    logic [31:0] r_csf;
    logic [31:0] r_mass;
    logic        w_fq_valid;
    logic        w_fq_ready;
    t_particle   w_fq_item;
    logic        w_qb_valid;
    logic        w_qb_ready;
    t_particle   w_qb_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_csf  <= 32'd0;
            r_mass <= 32'd65536;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CHARGE_STEP: r_csf  <= i_cfg_data;
                CFG_MASS:        r_mass <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    pkes_front #(.CELLS(CELLS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_cell_req     (i_cell_req),
        .i_coeff_select (i_coeff_select),
        .i_coeff_value  (i_coeff_value),
        .i_offset_x     (i_offset_x),
        .i_offset_y     (i_offset_y),
        .i_offset_z     (i_offset_z),
        .i_mom_x        (i_mom_x),
        .i_mom_y        (i_mom_y),
        .i_mom_z        (i_mom_z),
        .i_weight       (i_weight),
        .i_last         (i_last),
        .o_q_valid      (w_fq_valid),
        .i_q_ready      (w_fq_ready),
        .o_q_item       (w_fq_item)
    );

    pkes_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fq_valid),
        .o_ready (w_fq_ready),
        .i_item  (w_fq_item),
        .o_valid (w_qb_valid),
        .i_ready (w_qb_ready),
        .o_item  (w_qb_item)
    );

    pkes_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_qb_valid),
        .o_q_ready     (w_qb_ready),
        .i_q_item      (w_qb_item),
        .i_charge_step (r_csf),
        .i_mass        (r_mass),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_energy_sum  (o_energy_sum),
        .o_saturated   (o_saturated)
    );

endmodule

@@ hdl/pkes_front.sv @@
// ----------------------------------------------------------------------------
// pkes_front
// Takes input items, writes coefficient loads into the banked store and
// fetches the twelve coefficients of a particle's cell.
// ----------------------------------------------------------------------------
module pkes_front import pkes_pkg::*; #(
    parameter int CELLS = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_cmd,
    input  logic [CELL_REQ_W-1:0] i_cell_req,
    input  logic [3:0]            i_coeff_select,
    input  logic [31:0]           i_coeff_value,
    input  logic [15:0]           i_offset_x,
    input  logic [15:0]           i_offset_y,
    input  logic [15:0]           i_offset_z,
    input  logic [31:0]           i_mom_x,
    input  logic [31:0]           i_mom_y,
    input  logic [31:0]           i_mom_z,
    input  logic [31:0]           i_weight,
    input  logic                  i_last,
    output logic                  o_q_valid,
    input  logic                  i_q_ready,
    output t_particle             o_q_item
);

    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int IW = (AW > CELL_REQ_W) ? AW : CELL_REQ_W;

    logic                      w_acc;
    logic                      w_wr;
    logic                      w_rd;
    logic                      w_cell_ok;
    logic [IW-1:0]             w_cell;
    logic [AW-1:0]             w_addr;
    logic [NUM_COEF-1:0][31:0] r_rd;
    logic                      r_hold_v;
    logic                      r_ok;
    logic [2:0][15:0]          r_off;
    logic [2:0][31:0]          r_mom;
    logic [31:0]               r_w;
    logic                      r_last;

    assign w_cell    = IW'(i_cell_req);
    assign w_addr    = w_cell[AW-1:0];
    assign w_cell_ok = (32'(i_cell_req) < 32'(CELLS));
    assign o_in_ready = !r_hold_v || i_q_ready;
    assign w_acc     = i_in_valid && o_in_ready;
    assign w_wr      = w_acc && (i_cmd == CMD_LOAD) && w_cell_ok
                       && (i_coeff_select < 4'(NUM_COEF));
    assign w_rd      = w_acc && (i_cmd == CMD_PARTICLE);

    // one bank per coefficient so a whole cell reads at once
    for (genvar b = 0; b < NUM_COEF; b++) begin : g_bank
        logic [31:0] r_mem [CELLS];
        always_ff @(posedge i_clk) begin
            if (w_wr && (i_coeff_select == 4'(b))) begin
                r_mem[w_addr] <= i_coeff_value;
            end
            if (w_rd) begin
                r_rd[b] <= r_mem[w_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
        end else if (o_in_ready) begin
            r_hold_v <= w_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd) begin
            r_ok   <= w_cell_ok;
            r_off  <= {i_offset_z, i_offset_y, i_offset_x};
            r_mom  <= {i_mom_z, i_mom_y, i_mom_x};
            r_w    <= i_weight;
            r_last <= i_last;
        end
    end

    assign o_q_valid       = r_hold_v;
    assign o_q_item.coef   = r_ok ? r_rd : '0;
    assign o_q_item.off    = r_off;
    assign o_q_item.mom    = r_mom;
    assign o_q_item.weight = r_w;
    assign o_q_item.last   = r_last;

endmodule

@@ hdl/pkes_queue.sv @@
// ----------------------------------------------------------------------------
// pkes_queue
// Two-entry queue of fetched particles between front and back.
// ----------------------------------------------------------------------------
module pkes_queue import pkes_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_particle i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_particle o_item
);

    t_particle  r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

@@ hdl/pkes_back.sv @@
// ----------------------------------------------------------------------------
// pkes_back
// Per particle: field interpolation, momentum kick, u2, serial square root,
// serial divide, product by mass and weight, saturating accumulate.
// ----------------------------------------------------------------------------
module pkes_back import pkes_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    output logic        o_q_ready,
    input  t_particle   i_q_item,
    input  logic [31:0] i_charge_step,
    input  logic [31:0] i_mass,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_energy_sum,
    output logic        o_saturated
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SUM   = 4'd1;
    localparam logic [3:0] S_PROD  = 4'd2;
    localparam logic [3:0] S_FIELD = 4'd3;
    localparam logic [3:0] S_KICK  = 4'd4;
    localparam logic [3:0] S_VEL   = 4'd5;
    localparam logic [3:0] S_SQ    = 4'd6;
    localparam logic [3:0] S_SQRT  = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_MUL   = 4'd9;
    localparam logic [3:0] S_ACC   = 4'd10;
    localparam logic [3:0] S_EMIT  = 4'd11;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (x < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    logic [3:0]                r_state;
    logic [NUM_COEF-1:0][31:0] r_k;
    logic [2:0][15:0]          r_off;
    logic [2:0][31:0]          r_mom;
    logic [31:0]               r_w;
    logic                      r_last;
    logic [1:0]                r_ax;
    logic signed [48:0]        r_s1;
    logic signed [48:0]        r_s2;
    logic signed [64:0]        r_t;
    logic signed [31:0]        r_e;
    logic signed [63:0]        r_kick;
    logic signed [31:0]        r_v;
    logic [63:0]               r_u2;
    logic [63:0]               r_n;
    logic [33:0]               r_rem;
    logic [31:0]               r_root;
    logic [6:0]                r_cnt;
    logic [67:0]               r_dv;
    logic [32:0]               r_drem;
    logic [32:0]               r_den;
    logic [47:0]               r_q;
    logic [63:0]               r_mw;
    logic [111:0]              r_prod;
    logic [63:0]               r_acc;
    logic                      r_sat;
    logic                      r_out_v;
    logic [63:0]               r_out_sum;
    logic                      r_out_sat;

    logic signed [31:0]  w_k0, w_k1, w_k2, w_k3, w_mom;
    logic signed [15:0]  w_p, w_qo;
    logic signed [47:0]  w_m1, w_m3;
    logic signed [64:0]  w_t, w_tr;
    logic signed [50:0]  w_e35, w_er;
    logic signed [63:0]  w_kick, w_sq;
    logic signed [65:0]  w_kr, w_vs;
    logic [63:0]         w_u2n;
    logic [35:0]         w_rsh, w_trial;
    logic [31:0]         w_root_n;
    logic [33:0]         w_dsh;
    logic [31:0]         w_ma, w_mb;
    logic [63:0]         w_pp;
    logic [111:0]        w_ppsh;
    logic                w_clip;
    logic [63:0]         w_term;
    logic [64:0]         w_accs;

    // axis x uses (dy,dz), y uses (dz,dx), z uses (dx,dy)
    always_comb begin
        case (r_ax)
            2'd1: begin
                w_k0 = r_k[4]; w_k1 = r_k[5]; w_k2 = r_k[6]; w_k3 = r_k[7];
                w_p = r_off[2]; w_qo = r_off[0]; w_mom = r_mom[1];
            end
            2'd2: begin
                w_k0 = r_k[8]; w_k1 = r_k[9]; w_k2 = r_k[10]; w_k3 = r_k[11];
                w_p = r_off[0]; w_qo = r_off[1]; w_mom = r_mom[2];
            end
            default: begin
                w_k0 = r_k[0]; w_k1 = r_k[1]; w_k2 = r_k[2]; w_k3 = r_k[3];
                w_p = r_off[1]; w_qo = r_off[2]; w_mom = r_mom[0];
            end
        endcase
    end

    assign w_m1   = w_p * w_k1;
    assign w_m3   = w_p * w_k3;
    assign w_t    = w_qo * r_s2;
    assign w_tr   = (r_t + 65'sd16384) >>> 15;
    assign w_e35  = 51'(r_s1) + $signed(w_tr[50:0]);
    assign w_er   = (w_e35 + 51'sd16384) >>> 15;
    assign w_kick = r_e * $signed(i_charge_step);
    assign w_kr   = (66'(r_kick) + 66'sd524288) >>> 20;
    assign w_vs   = 66'(w_mom) + w_kr;
    assign w_sq   = r_v * r_v;
    assign w_u2n  = r_u2 + $unsigned(w_sq);

    // square root, two radicand bits per step
    assign w_rsh    = {r_rem, r_n[63:62]};
    assign w_trial  = {2'b00, r_root, 2'b01};
    assign w_root_n = (w_rsh >= w_trial) ? {r_root[30:0], 1'b1} : {r_root[30:0], 1'b0};

    // restoring divide, one quotient bit per step
    assign w_dsh = {r_drem, r_dv[67]};

    // 64 x 48 product from 32 x 32 partials
    assign w_ma = r_cnt[1] ? r_mw[63:32] : r_mw[31:0];
    assign w_mb = r_cnt[0] ? {16'd0, r_q[47:32]} : r_q[31:0];
    assign w_pp = w_ma * w_mb;
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    w_ppsh = 112'(w_pp);
            2'd3:    w_ppsh = 112'(w_pp) << 64;
            default: w_ppsh = 112'(w_pp) << 32;
        endcase
    end

    assign w_clip = (r_prod[111:96] != 16'd0);
    assign w_term = w_clip ? '1 : r_prod[95:32];
    assign w_accs = 65'(r_acc) + 65'(w_term);

    assign o_q_ready    = (r_state == S_IDLE);
    assign o_out_valid  = r_out_v;
    assign o_energy_sum = r_out_sum;
    assign o_saturated  = r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acc   <= '0;
            r_sat   <= 1'b0;
            r_out_v <= 1'b0;
            r_cnt   <= '0;
            r_ax    <= '0;
        end else begin
            if (r_out_v && i_out_ready) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_ax    <= 2'd0;
                        r_state <= S_SUM;
                    end
                end
                S_SUM:   r_state <= S_PROD;
                S_PROD:  r_state <= S_FIELD;
                S_FIELD: r_state <= S_KICK;
                S_KICK:  r_state <= S_VEL;
                S_VEL:   r_state <= S_SQ;
                S_SQ: begin
                    r_cnt <= '0;
                    if (r_ax == 2'd2) begin
                        r_state <= S_SQRT;
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= S_SUM;
                    end
                end
                S_SQRT: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd31) begin
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd67) begin
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd3) begin
                        r_cnt   <= '0;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_acc   <= w_accs[64] ? '1 : w_accs[63:0];
                    r_sat   <= r_sat | w_clip | w_accs[64];
                    r_state <= r_last ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (!r_out_v) begin
                        r_out_v <= 1'b1;
                        r_acc   <= '0;
                        r_sat   <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_k    <= i_q_item.coef;
                r_off  <= i_q_item.off;
                r_mom  <= i_q_item.mom;
                r_w    <= i_q_item.weight;
                r_last <= i_q_item.last;
                r_u2   <= '0;
            end
            S_SUM: begin
                r_s1 <= (49'(w_k0) <<< 15) + 49'(w_m1);
                r_s2 <= (49'(w_k2) <<< 15) + 49'(w_m3);
            end
            S_PROD:  r_t    <= w_t;
            S_FIELD: r_e    <= sat32(66'(w_er));
            S_KICK:  r_kick <= w_kick;
            S_VEL:   r_v    <= sat32(w_vs);
            S_SQ: begin
                r_u2   <= w_u2n;
                r_n    <= w_u2n + 64'h0000_0100_0000_0000;
                r_rem  <= '0;
                r_root <= '0;
            end
            S_SQRT: begin
                r_n    <= {r_n[61:0], 2'b00};
                r_root <= w_root_n;
                r_rem  <= (w_rsh >= w_trial) ? 34'(w_rsh - w_trial) : w_rsh[33:0];
                if (r_cnt == 7'd31) begin
                    r_den  <= 33'h0_0010_0000 + {1'b0, w_root_n};
                    r_dv   <= {r_u2, 4'b0000};
                    r_drem <= '0;
                    r_mw   <= i_mass * r_w;
                end
            end
            S_DIV: begin
                r_dv <= {r_dv[66:0], 1'b0};
                if (w_dsh >= {1'b0, r_den}) begin
                    r_drem <= 33'(w_dsh - {1'b0, r_den});
                    r_q    <= {r_q[46:0], 1'b1};
                end else begin
                    r_drem <= w_dsh[32:0];
                    r_q    <= {r_q[46:0], 1'b0};
                end
                r_prod <= '0;
            end
            S_MUL: r_prod <= r_prod + w_ppsh;
            S_EMIT: begin
                if (!r_out_v) begin
                    r_out_sum <= r_acc;
                    r_out_sat <= r_sat;
                end
            end
            default: ;
        endcase
    end

endmodule

@@ hdl/pkes_checker.sv @@
// ----------------------------------------------------------------------------
// pkes_checker
// Port-level checks of the kinetic energy sum unit.
// ----------------------------------------------------------------------------
`include "particle_kinetic_energy_sum_unit_assert.svh"

module pkes_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [63:0] o_energy_sum,
    input logic        o_saturated,
    input logic        o_cfg_ready
);

    // a stalled result holds its value
    `PKES_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_energy_sum) && $stable(o_saturated), "result changed while stalled")

    // any clipping drives the sum to its ceiling
    `PKES_ASSERT_IMP(a_sat_max, i_clk, i_rst_n, o_out_valid && o_saturated, o_energy_sum == 64'hffff_ffff_ffff_ffff, "saturated sum below maximum")

    // register writes never stall
    `PKES_ASSERT_IMP(a_cfg_ready, i_clk, i_rst_n, 1'b1, o_cfg_ready, "config port not ready")

endmodule

bind particle_kinetic_energy_sum_unit pkes_checker u_pkes_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_energy_sum (o_energy_sum),
    .o_saturated  (o_saturated),
    .o_cfg_ready  (o_cfg_ready)
);
